// ===== rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/chbd_pkg.sv =====
// types, constants and helpers for the chunked body decoder
`timescale 1ns / 1ps
package chbd_pkg;

    localparam int COUNT_BITS_DEF  = 32;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int LEN_BITS        = 32;

    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_9    = 8'h39;
    localparam logic [7:0] CHAR_LA   = 8'h61;
    localparam logic [7:0] CHAR_LF_HI = 8'h66;
    localparam logic [7:0] CHAR_UA   = 8'h41;
    localparam logic [7:0] CHAR_UF   = 8'h46;
    localparam logic [7:0] CHAR_SEMI = 8'h3b;
    localparam logic [7:0] CHAR_CR   = 8'h0d;
    localparam logic [7:0] CHAR_LF   = 8'h0a;

    typedef enum logic [4:0] {
        PH_SIZE   = 5'b00001,
        PH_SKIPLF = 5'b00010,
        PH_DATA   = 5'b00100,
        PH_TRAIL  = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [LEN_BITS-1:0] decoded_length;
        logic                body_done;
        logic                payload_valid;
        logic [7:0]          payload_byte;
    } result_t;

    typedef struct packed {
        logic in_done;
    } front_status_t;

    // msb flags a hex digit, low nibble is its value
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= CHAR_0 && c <= CHAR_9)
            r = {1'b1, 4'(c - CHAR_0)};
        else if (c >= CHAR_LA && c <= CHAR_LF_HI)
            r = {1'b1, 4'(c - CHAR_LA + 8'd10)};
        else if (c >= CHAR_UA && c <= CHAR_UF)
            r = {1'b1, 4'(c - CHAR_UA + 8'd10)};
        return r;
    endfunction

endpackage

// ===== rtl/chbd_front.sv =====
// front end: chunk framing state machine, classifies each body byte
`timescale 1ns / 1ps
module chbd_front #(
    parameter int COUNT_BITS = chbd_pkg::COUNT_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              body_byte,
    input  logic                    start_of_body,
    input  logic                    end_of_buffer,
    input  logic                    q_space,
    output logic                    push,
    output chbd_pkg::result_t       push_data,
    output chbd_pkg::front_status_t status
);

    chbd_pkg::phase_t       phase_reg, phase_next, ph;
    logic [COUNT_BITS-1:0]  chunk_reg, chunk_next, cs;
    logic [COUNT_BITS-1:0]  left_reg, left_next, bl;
    logic [1:0]             trail_reg, trail_next, tl;
    logic [COUNT_BITS-1:0]  count_reg, count_next, oc;
    logic [COUNT_BITS+chbd_pkg::LEN_BITS-1:0] count_ext;
    logic [4:0]             hex;
    logic                   accept, emit, done, live;

    assign in_ready = q_space;
    assign accept   = in_valid && in_ready;
    assign hex      = chbd_pkg::hex_decode(body_byte);

    always_comb begin
        // start of body behaves as a reset ahead of this byte
        ph = start_of_body ? chbd_pkg::PH_SIZE : phase_reg;
        cs = start_of_body ? '0 : chunk_reg;
        bl = start_of_body ? '0 : left_reg;
        tl = start_of_body ? 2'd0 : trail_reg;
        oc = start_of_body ? '0 : count_reg;
        phase_next = ph;
        chunk_next = cs;
        left_next  = bl;
        trail_next = tl;
        count_next = oc;
        emit = 1'b0;
        done = 1'b0;
        live = 1'b1;
        unique case (ph)
            chbd_pkg::PH_SIZE: begin
                if (hex[4])
                    chunk_next = {cs[COUNT_BITS-5:0], hex[3:0]};
                else if (body_byte == chbd_pkg::CHAR_SEMI || body_byte == chbd_pkg::CHAR_CR)
                    phase_next = chbd_pkg::PH_SKIPLF;
            end
            chbd_pkg::PH_SKIPLF: begin
                if (body_byte == chbd_pkg::CHAR_LF) begin
                    if (cs == '0) begin
                        phase_next = chbd_pkg::PH_DONE;
                        done = 1'b1;
                    end else begin
                        left_next  = cs;
                        phase_next = chbd_pkg::PH_DATA;
                    end
                end
            end
            chbd_pkg::PH_DATA: begin
                emit       = 1'b1;
                count_next = oc + 1'b1;
                left_next  = bl - 1'b1;
                if (bl == COUNT_BITS'(1)) begin
                    trail_next = 2'd2;
                    phase_next = chbd_pkg::PH_TRAIL;
                end
            end
            chbd_pkg::PH_TRAIL: begin
                trail_next = tl - 1'b1;
                if (tl == 2'd1) begin
                    chunk_next = '0;
                    phase_next = chbd_pkg::PH_SIZE;
                end
            end
            default: live = 1'b0;
        endcase
        if (live && end_of_buffer && phase_next != chbd_pkg::PH_DONE) begin
            phase_next = chbd_pkg::PH_DONE;
            done = 1'b1;
        end
    end

    assign count_ext = {{chbd_pkg::LEN_BITS{1'b0}}, count_next};
    assign push      = accept && (emit || done);
    assign push_data.payload_byte   = emit ? body_byte : 8'd0;
    assign push_data.payload_valid  = emit;
    assign push_data.body_done      = done;
    assign push_data.decoded_length = count_ext[chbd_pkg::LEN_BITS-1:0];
    assign status.in_done           = (phase_reg == chbd_pkg::PH_DONE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= chbd_pkg::PH_SIZE;
            chunk_reg <= '0;
            left_reg  <= '0;
            trail_reg <= 2'd0;
            count_reg <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            chunk_reg <= chunk_next;
            left_reg  <= left_next;
            trail_reg <= trail_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/chbd_queue.sv =====
// back end: result queue feeding the output stream
`timescale 1ns / 1ps
module chbd_queue #(
    parameter int QUEUE_DEPTH = chbd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           push,
    input  chbd_pkg::result_t              push_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output chbd_pkg::result_t              out_data,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] fill
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    chbd_pkg::result_t mem [QUEUE_DEPTH];
    chbd_pkg::result_t out_data_reg;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_data  = out_data_reg;
    assign fill      = count_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
        // head beat is read ahead, a beat landing at the head bypasses the array
        if (push && wr_ptr_reg == rd_ptr_next)
            out_data_reg <= push_data;
        else
            out_data_reg <= mem[rd_ptr_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/http_chunked_body_decoder.sv =====
// Chunked transfer decoder for the body of an HTTP/1.1 response.
// Slave stream: one body byte per beat in s_tdata, s_tuser marks the first
// byte of a new body (clears all framing state), s_tlast the last byte of
// the receive buffer. Master stream: one beat per payload byte, per
// zero-size chunk line end, and per last byte of an open body. m_tuser
// says the beat carries a payload byte, m_tlast ends the body, and
// m_tdata carries the byte and the running count of payload bytes.
// Throughput is one byte per cycle while the result queue has space;
// the framing state machine computes its next state combinationally.
// Results pass through a small result queue (default 4 beats).
// When the receiver stalls, the queue absorbs results and s_tready falls
// only once it is full; bytes that yield no result still need a free slot.
// After reset the decoder waits for a chunk-size line with zero count;
// bytes after the end of a body are dropped until s_tuser is seen.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module http_chunked_body_decoder #(
    parameter int COUNT_BITS  = chbd_pkg::COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH = chbd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] body_byte
    input  logic        s_tuser,   // [0] start_of_body
    input  logic        s_tlast,   // end_of_buffer
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] payload_byte, [39:8] decoded_length
    output logic        m_tuser,   // [0] payload_valid
    output logic        m_tlast    // body_done
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic                    q_space;
    logic                    push;
    chbd_pkg::result_t       push_data;
    chbd_pkg::result_t       out_data;
    chbd_pkg::front_status_t front_status;
    logic [CW-1:0]           q_fill;

    assign q_space = (q_fill != CW'(QUEUE_DEPTH));

    chbd_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .body_byte     (s_tdata),
        .start_of_body (s_tuser),
        .end_of_buffer (s_tlast),
        .q_space       (q_space),
        .push          (push),
        .push_data     (push_data),
        .status        (front_status)
    );

    chbd_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data),
        .fill      (q_fill)
    );

    assign m_tdata = {out_data.decoded_length, out_data.payload_byte};
    assign m_tuser = out_data.payload_valid;
    assign m_tlast = out_data.body_done;

    // a done result always leaves the framer in its done state
    `ASSERT_NEXT(a_done_sticks, aclk, aresetn, push && push_data.body_done, front_status.in_done)
    // queue fill tracks push without pop
    `ASSERT_NEXT(a_fill_up, aclk, aresetn, push && !(m_tvalid && m_tready), q_fill == $past(q_fill) + 1'b1)
    // non-payload beats carry a zero byte
    `ASSERT_IMPLIES(a_zero_byte, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[7:0] == 8'd0)

endmodule

// ===== test/http_chunked_body_decoder_tb.sv =====
// self-checking testbench for the http chunked body decoder
`timescale 1ns / 1ps
module http_chunked_body_decoder_tb;

    typedef struct {
        logic [7:0] data;
        logic       sob;
        logic       eob;
        logic       drain;
    } body_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    body_beat_t          body_q[$];
    chbd_pkg::result_t   decoded_q[$];
    body_beat_t          next_beat;
    chbd_pkg::result_t   want;
    logic       next_sob = 1'b0;
    logic       next_drain = 1'b0;
    logic       in_taken = 1'b0;
    int         cyc = 0;
    int         mismatches = 0;
    int         body_cnt = 0;
    logic       calm;

    // decoder model state
    chbd_pkg::phase_t dec_phase = chbd_pkg::PH_SIZE;
    logic [31:0] dec_size = '0;
    logic [31:0] dec_left = '0;
    logic [1:0]  dec_trail = '0;
    logic [31:0] dec_count = '0;

    http_chunked_body_decoder i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    // no random idling on either side inside this window
    assign calm = (cyc >= 250) && (cyc < 500);

    task automatic decode_body_byte(input body_beat_t bt);
        logic       emit;
        logic       done;
        logic       hit;
        logic [3:0] nib;
        chbd_pkg::result_t r;
        emit = 1'b0;
        done = 1'b0;
        hit = 1'b0;
        nib = '0;
        if (bt.sob) begin
            dec_phase = chbd_pkg::PH_SIZE;
            dec_size = '0;
            dec_left = '0;
            dec_trail = '0;
            dec_count = '0;
        end
        if (dec_phase == chbd_pkg::PH_DONE)
            return;
        case (dec_phase)
            chbd_pkg::PH_SIZE: begin
                if (bt.data >= chbd_pkg::CHAR_0 && bt.data <= chbd_pkg::CHAR_9) begin
                    hit = 1'b1;
                    nib = 4'(bt.data - chbd_pkg::CHAR_0);
                end else if (bt.data >= chbd_pkg::CHAR_LA
                        && bt.data <= chbd_pkg::CHAR_LF_HI) begin
                    hit = 1'b1;
                    nib = 4'(bt.data - chbd_pkg::CHAR_LA + 8'd10);
                end else if (bt.data >= chbd_pkg::CHAR_UA && bt.data <= chbd_pkg::CHAR_UF) begin
                    hit = 1'b1;
                    nib = 4'(bt.data - chbd_pkg::CHAR_UA + 8'd10);
                end
                if (hit)
                    dec_size = {dec_size[27:0], nib};
                else if (bt.data == chbd_pkg::CHAR_SEMI || bt.data == chbd_pkg::CHAR_CR)
                    dec_phase = chbd_pkg::PH_SKIPLF;
            end
            chbd_pkg::PH_SKIPLF: begin
                if (bt.data == chbd_pkg::CHAR_LF) begin
                    if (dec_size == 0) begin
                        dec_phase = chbd_pkg::PH_DONE;
                        done = 1'b1;
                    end else begin
                        dec_left = dec_size;
                        dec_phase = chbd_pkg::PH_DATA;
                    end
                end
            end
            chbd_pkg::PH_DATA: begin
                emit = 1'b1;
                dec_count = dec_count + 1;
                dec_left = dec_left - 1;
                if (dec_left == 0) begin
                    dec_trail = 2'd2;
                    dec_phase = chbd_pkg::PH_TRAIL;
                end
            end
            default: begin
                dec_trail = dec_trail - 1;
                if (dec_trail == 0) begin
                    dec_size = '0;
                    dec_phase = chbd_pkg::PH_SIZE;
                end
            end
        endcase
        if (bt.eob && dec_phase != chbd_pkg::PH_DONE) begin
            dec_phase = chbd_pkg::PH_DONE;
            done = 1'b1;
        end
        if (emit || done) begin
            r.payload_byte = emit ? bt.data : 8'h00;
            r.payload_valid = emit;
            r.body_done = done;
            r.decoded_length = dec_count;
            decoded_q.push_back(r);
        end
    endtask

    // input acceptance, prediction and result checking
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        in_taken <= s_tvalid && s_tready && aresetn;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                next_beat.data = s_tdata;
                next_beat.sob = s_tuser;
                next_beat.eob = s_tlast;
                next_beat.drain = 1'b0;
                decode_body_byte(next_beat);
            end
            if (m_tvalid && m_tready) begin
                if (decoded_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: byte %02h valid %0d done %0d len %0d",
                                 m_tdata[7:0], m_tuser, m_tlast, m_tdata[39:8]);
                end else begin
                    want = decoded_q.pop_front();
                    if (want.payload_byte !== m_tdata[7:0] || want.payload_valid !== m_tuser
                            || want.body_done !== m_tlast
                            || want.decoded_length !== m_tdata[39:8]) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("mismatch: expected byte %02h valid %0d done %0d len %0d,",
                                   want.payload_byte, want.payload_valid, want.body_done,
                                   want.decoded_length);
                            $display(" got byte %02h valid %0d done %0d len %0d",
                                     m_tdata[7:0], m_tuser, m_tlast, m_tdata[39:8]);
                        end
                    end
                end
            end
        end
    end

    // byte driver and receiver stalls
    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 10);
        if (aresetn && (!s_tvalid || in_taken)) begin
            if (body_q.size() != 0 && (calm || $urandom_range(99) >= 10)
                    && !(body_q[0].drain && decoded_q.size() != 0)) begin
                next_beat = body_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= next_beat.data;
                s_tuser <= next_beat.sob;
                s_tlast <= next_beat.eob;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    task automatic push_byte(input logic [7:0] d, input logic eob = 1'b0);
        body_beat_t bt;
        bt.data = d;
        bt.sob = next_sob;
        bt.eob = eob;
        bt.drain = next_drain;
        next_sob = 1'b0;
        next_drain = 1'b0;
        body_q.push_back(bt);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    task automatic push_hex_digit(input logic [3:0] v);
        if (v < 10)
            push_byte(8'(chbd_pkg::CHAR_0 + v));
        else if ($urandom_range(1))
            push_byte(8'(chbd_pkg::CHAR_LA + v - 10));
        else
            push_byte(8'(chbd_pkg::CHAR_UA + v - 10));
    endtask

    task automatic push_size_line(input logic [31:0] sz);
        int   ndig;
        int   lead;
        logic [7:0] b;
        ndig = 1;
        while (ndig < 8 && (sz >> (4 * ndig)) != 0)
            ndig++;
        lead = 0;
        if ($urandom_range(9) == 0) begin
            // overlong line: extra high digits fall off the counter
            ndig = 8;
            lead = $urandom_range(1, 3);
        end else if ($urandom_range(5) == 0) begin
            lead = $urandom_range(1, 2);
        end
        for (int i = 0; i < lead; i++)
            push_hex_digit(ndig == 8 ? 4'($urandom_range(15)) : 4'h0);
        for (int i = ndig - 1; i >= 0; i--) begin
            push_hex_digit(4'(sz >> (4 * i)));
            if (i != 0 && $urandom_range(7) == 0) begin
                case ($urandom_range(4))
                    0: push_byte("g");
                    1: push_byte(" ");
                    2: push_byte(chbd_pkg::CHAR_LF);
                    3: push_byte("Z");
                    default: push_byte(8'h80);
                endcase
            end
        end
        case ($urandom_range(3))
            0: push_text(";name=v\r\n");
            1: begin
                push_byte($urandom_range(1) ? chbd_pkg::CHAR_SEMI : chbd_pkg::CHAR_CR);
                for (int i = $urandom_range(0, 3); i > 0; i--) begin
                    b = 8'($urandom_range(255));
                    push_byte(b == chbd_pkg::CHAR_LF ? 8'h78 : b);
                end
                push_byte(chbd_pkg::CHAR_LF);
            end
            default: push_text("\r\n");
        endcase
    endtask

    task automatic add_random_body();
        int          nchunk;
        int          ending;
        int          first;
        int          cut;
        logic [31:0] sz;
        body_cnt++;
        ending = $urandom_range(9);
        if (ending == 9) begin
            // noise burst with random framing flags
            for (int i = $urandom_range(1, 6); i > 0; i--) begin
                next_sob = ($urandom_range(9) == 0);
                push_byte(8'($urandom_range(255)), $urandom_range(4) == 0);
            end
            return;
        end
        first = body_q.size();
        next_sob = 1'b1;
        next_drain = (body_cnt % 6 == 0);
        nchunk = $urandom_range(1, 4);
        for (int c = 0; c < nchunk; c++) begin
            sz = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            push_size_line(sz);
            for (int i = 0; i < sz; i++)
                push_byte(8'($urandom_range(255)));
            if ($urandom_range(1))
                push_text("\r\n");
            else begin
                push_byte(8'($urandom_range(255)));
                push_byte(8'($urandom_range(255)));
            end
        end
        if (ending == 7) begin
            // buffer ends somewhere inside the body, the rest is dropped
            cut = $urandom_range(first, body_q.size() - 1);
            body_q[cut].eob = 1'b1;
            return;
        end
        push_size_line(32'd0);
        if (ending == 6)
            body_q[$].eob = 1'b1;
        if (ending == 8) begin
            for (int i = $urandom_range(1, 3); i > 0; i--)
                push_byte(8'($urandom_range(255)), $urandom_range(1));
        end
    endtask

    initial begin
        // directed: byte extremes, extension, arbitrary trailer, zero chunk
        next_sob = 1'b1;
        push_text("2;x\r\n");
        push_byte(8'h00);
        push_byte(8'hff);
        push_byte(8'ha5);
        push_byte(chbd_pkg::CHAR_LF);
        push_text("0\r\n");
        // ignored after done, even with end of buffer
        push_byte("A");
        push_byte("Z", 1'b1);
        // lf among the digits, end of buffer on a payload byte
        next_sob = 1'b1;
        push_text("0\n1\r\n");
        push_byte("q", 1'b1);
        // zero size and end of buffer on one lf, sent once all is drained
        next_sob = 1'b1;
        next_drain = 1'b1;
        push_text("0\r");
        push_byte(chbd_pkg::CHAR_LF, 1'b1);
        // end of buffer inside the size line
        next_sob = 1'b1;
        push_byte("x", 1'b1);
        while (body_q.size() < 575)
            add_random_body();

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        while (body_q.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (decoded_q.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && decoded_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #1000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== http_chunked_body_decoder.f =====
+incdir+rtl
rtl/chbd_pkg.sv
rtl/chbd_front.sv
rtl/chbd_queue.sv
rtl/http_chunked_body_decoder.sv
test/http_chunked_body_decoder_tb.sv
